### design/double_to_hex_digits_macros.svh
// ----------------------------------------------------------------------------
// double_to_hex_digits assertion macros
// Shared concurrent assertion forms for the hex digit generator.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_TO_HEX_DIGITS_MACROS_SVH
`define DOUBLE_TO_HEX_DIGITS_MACROS_SVH

`ifndef SYNTHESIS

// antecedent holds in the same cycle as the consequent
`define DTHD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dthd assertion failed");

// consequent holds in the cycle after the antecedent
`define DTHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dthd assertion failed");

`else

`define DTHD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DTHD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/dthd_pkg.sv
// ----------------------------------------------------------------------------
// dthd_pkg
// Types, codes and character helpers for the hex digit generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dthd_pkg;

    // digit count limits
    localparam int MAX_DIGITS  = 32;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int NIBBLES     = 14;
    localparam int SIG_W       = 4 * NIBBLES;

    // result queue
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // number classes
    localparam logic [1:0] CLS_FINITE = 2'd0;
    localparam logic [1:0] CLS_ZERO   = 2'd1;
    localparam logic [1:0] CLS_INF    = 2'd2;
    localparam logic [1:0] CLS_NAN    = 2'd3;

    // rounding modes
    localparam logic [1:0] RM_ZERO    = 2'd0;
    localparam logic [1:0] RM_NEAREST = 2'd1;
    localparam logic [1:0] RM_UP      = 2'd2;
    localparam logic [1:0] RM_DOWN    = 2'd3;

    // configuration register indexes
    localparam logic REG_ROUNDING = 1'b0;
    localparam logic REG_UPPER    = 1'b1;

    // aligned significand after the front stages
    typedef struct packed {
        logic [1:0]        cls;
        logic              neg;
        logic signed [11:0] exp;
        logic [SIG_W-1:0]  sig;
        logic [6:0]        req;
    } front_t;

    // finished conversion waiting for the serialiser
    typedef struct packed {
        logic [1:0]        cls;
        logic              neg;
        logic signed [11:0] exp;
        logic [SIG_W-1:0]  digits;
        logic [CNT_W-1:0]  nd;
    } item_t;

    // ascii code of one hex digit
    function automatic logic [6:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [6:0] c;
        if (nib < 4'd10)
            c = 7'h30 + {3'b000, nib};
        else if (upper)
            c = 7'h41 + {3'b000, nib} - 7'd10;
        else
            c = 7'h61 + {3'b000, nib} - 7'd10;
        return c;
    endfunction

    // ascii code of a character of the fixed names
    function automatic logic [6:0] text_char(input logic [1:0] cls,
                                             input logic [CNT_W-1:0] pos);
        logic [7:0] c;
        c = "0";
        if (cls == CLS_INF) begin
            case (pos[2:0])
                3'd0:    c = "I";
                3'd1:    c = "n";
                3'd2:    c = "f";
                3'd3:    c = "i";
                3'd4:    c = "n";
                3'd5:    c = "i";
                3'd6:    c = "t";
                3'd7:    c = "y";
                default: c = "y";
            endcase
        end else if (cls == CLS_NAN) begin
            case (pos[1:0])
                2'd1:    c = "a";
                default: c = "N";
            endcase
        end
        return c[6:0];
    endfunction

endpackage

### design/dthd_front.sv
// ----------------------------------------------------------------------------
// dthd_front
// Stages one and two: classify, find the top bit of a subnormal, align the
// significand into fourteen nibbles and form the exponent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dthd_front
    import dthd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [63:0] value_bits,
    input  logic [6:0]  requested_digits,
    output logic        out_valid,
    output front_t      out_word
);

    // stage one registers
    logic        s1_valid_reg;
    logic [1:0]  s1_cls_reg, s1_cls_next;
    logic        s1_neg_reg;
    logic [10:0] s1_ex_reg;
    logic [51:0] s1_m_reg;
    logic [5:0]  s1_hb_reg, s1_hb_next;
    logic [6:0]  s1_req_reg;

    // stage two registers
    logic        s2_valid_reg;
    front_t      s2_word_reg, s2_word_next;

    // classify and priority-encode the fraction
    always_comb
    begin
        logic [10:0] ex;
        logic [51:0] m;
        ex = value_bits[62:52];
        m  = value_bits[51:0];
        if (ex == 11'h7FF)
            s1_cls_next = (m != 52'd0) ? CLS_NAN : CLS_INF;
        else if (ex == 11'd0 && m == 52'd0)
            s1_cls_next = CLS_ZERO;
        else
            s1_cls_next = CLS_FINITE;
        s1_hb_next = 6'd0;
        for (int i = 0; i < 52; i++)
        begin
            if (m[i])
                s1_hb_next = 6'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_cls_reg <= s1_cls_next;
        s1_neg_reg <= value_bits[63];
        s1_ex_reg  <= value_bits[62:52];
        s1_m_reg   <= value_bits[51:0];
        s1_hb_reg  <= s1_hb_next;
        s1_req_reg <= requested_digits;
    end

    // align subnormals on nibbles and work out the exponent
    always_comb
    begin
        logic [3:0] lz;
        logic [6:0] sh;
        lz = 4'd13 - s1_hb_reg[5:2];
        sh = 7'd55 - {1'b0, s1_hb_reg};
        sh[1:0] = 2'b00;
        s2_word_next.cls = s1_cls_reg;
        s2_word_next.neg = s1_neg_reg;
        s2_word_next.req = s1_req_reg;
        if (s1_ex_reg != 11'd0)
        begin
            s2_word_next.sig = {4'h1, s1_m_reg};
            s2_word_next.exp = $signed({1'b0, s1_ex_reg}) - 12'sd1022;
        end
        else
        begin
            s2_word_next.sig = {4'h0, s1_m_reg} << {lz, 2'b00};
            s2_word_next.exp = -12'sd1021 - $signed({5'b00000, sh});
        end
        case (s1_cls_reg)
            CLS_ZERO:         s2_word_next.exp = 12'sd1;
            CLS_INF, CLS_NAN: s2_word_next.exp = 12'sd0;
            default:          ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_word_reg <= s2_word_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_word  = s2_word_reg;

endmodule

### design/dthd_round.sv
// ----------------------------------------------------------------------------
// dthd_round
// Stages three and four: settle the digit count, decide rounding from the
// cut-off nibbles, then add the increment and handle a full carry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dthd_round
    import dthd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  rounding_mode,
    input  logic        in_valid,
    input  front_t      in_word,
    output logic        out_valid,
    output item_t       out_item
);

    // stage three registers
    logic             s3_valid_reg;
    logic [1:0]       s3_cls_reg;
    logic             s3_neg_reg;
    logic signed [11:0] s3_exp_reg;
    logic [CNT_W-1:0] s3_nd_reg, s3_nd_next;
    logic [SIG_W-1:0] s3_kept_reg, s3_kept_next;
    logic [SIG_W-1:0] s3_inc_reg, s3_inc_next;

    // stage four registers
    logic             s4_valid_reg;
    item_t            s4_item_reg, s4_item_next;

    // digit count and rounding decision
    always_comb
    begin
        logic [6:0]       rq;
        logic [CNT_W-1:0] nd_short;
        logic [3:0]       nib;
        logic [3:0]       first;
        logic [3:0]       lastk;
        logic             rest;
        logic             any;
        logic             up;
        rq = in_word.req;
        nd_short = CNT_W'(1);
        for (int i = 0; i < NIBBLES; i++)
        begin
            if (in_word.sig[SIG_W-1-4*i -: 4] != 4'd0)
                nd_short = CNT_W'(i + 1);
        end
        if (rq[6])
            s3_nd_next = nd_short;
        else if (rq[5:0] == 6'd0)
            s3_nd_next = CNT_W'(1);
        else if (int'(rq[5:0]) > MAX_DIGITS)
            s3_nd_next = CNT_W'(MAX_DIGITS);
        else
            s3_nd_next = CNT_W'(rq[5:0]);

        first = 4'd0;
        lastk = 4'd0;
        rest  = 1'b0;
        s3_kept_next = in_word.sig;
        for (int i = 0; i < NIBBLES; i++)
        begin
            nib = in_word.sig[SIG_W-1-4*i -: 4];
            if (CNT_W'(i) == s3_nd_next)
                first = nib;
            if (CNT_W'(i) > s3_nd_next && nib != 4'd0)
                rest = 1'b1;
            if (CNT_W'(i + 1) == s3_nd_next)
                lastk = nib;
            if (CNT_W'(i) >= s3_nd_next)
                s3_kept_next[SIG_W-1-4*i -: 4] = 4'd0;
        end
        any = (first != 4'd0) || rest;
        case (rounding_mode)
            RM_NEAREST: up = (first > 4'd8) || (first == 4'd8 && (rest || lastk[0]));
            RM_UP:      up = any && !in_word.neg;
            RM_DOWN:    up = any && in_word.neg;
            default:    up = 1'b0;
        endcase
        if (up)
            s3_inc_next = SIG_W'(1) << (4 * (NIBBLES - int'(s3_nd_next)));
        else
            s3_inc_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s3_cls_reg  <= in_word.cls;
        s3_neg_reg  <= in_word.neg;
        s3_exp_reg  <= in_word.exp;
        s3_nd_reg   <= s3_nd_next;
        s3_kept_reg <= s3_kept_next;
        s3_inc_reg  <= s3_inc_next;
    end

    // apply the increment, a carry out of the top renormalises
    always_comb
    begin
        logic [SIG_W:0] sum;
        sum = {1'b0, s3_kept_reg} + {1'b0, s3_inc_reg};
        s4_item_next.neg = s3_neg_reg;
        s4_item_next.cls = s3_cls_reg;
        if (sum[SIG_W])
        begin
            s4_item_next.digits = {4'h1, {(SIG_W - 4){1'b0}}};
            s4_item_next.exp    = s3_exp_reg + 12'sd4;
        end
        else
        begin
            s4_item_next.digits = sum[SIG_W-1:0];
            s4_item_next.exp    = s3_exp_reg;
        end
        case (s3_cls_reg)
            CLS_INF:  s4_item_next.nd = CNT_W'(8);
            CLS_NAN:  s4_item_next.nd = CNT_W'(3);
            CLS_ZERO: s4_item_next.nd = CNT_W'(1);
            default:  s4_item_next.nd = s3_nd_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_item_reg <= s4_item_next;
    end

    assign out_valid = s4_valid_reg;
    assign out_item  = s4_item_reg;

endmodule

### design/dthd_emit.sv
// ----------------------------------------------------------------------------
// dthd_emit
// Queue of finished conversions and the serialiser that sends one character
// word per cycle from the head of the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_to_hex_digits_macros.svh"

module dthd_emit
    import dthd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               upper_case,
    input  logic               in_valid,
    input  item_t              in_item,
    output logic               pop,
    output logic               result_valid,
    output logic [1:0]         number_class,
    output logic               negative,
    output logic signed [11:0] binary_exponent,
    output logic [6:0]         character,
    output logic               last
);

    // queue storage and pointers
    item_t             q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;

    // output registers
    logic               result_valid_reg;
    logic [1:0]         class_reg;
    logic               neg_reg;
    logic signed [11:0] exp_reg;
    logic [6:0]         char_reg, char_next;
    logic               last_reg, last_next;

    item_t             head;
    logic              have_head;

    assign head      = q_mem_reg[rd_ptr_reg];
    assign have_head = (count_reg != '0);

    // pick the character at the current position of the head item
    always_comb
    begin
        logic [3:0] nib;
        nib = 4'd0;
        for (int i = 0; i < NIBBLES; i++)
        begin
            if (pos_reg == CNT_W'(i))
                nib = head.digits[SIG_W-1-4*i -: 4];
        end
        if (head.cls == CLS_FINITE)
            char_next = hex_char(nib, upper_case);
        else
            char_next = text_char(head.cls, pos_reg);
        last_next = (pos_reg == head.nd - CNT_W'(1));
    end

    // queue bookkeeping
    always_comb
    begin
        pop         = have_head && last_next;
        wr_ptr_next = in_valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(in_valid) - QCNT_W'(pop);
        if (pop)
            pos_next = '0;
        else if (have_head)
            pos_next = pos_reg + CNT_W'(1);
        else
            pos_next = pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
            pos_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg       <= wr_ptr_next;
            rd_ptr_reg       <= rd_ptr_next;
            count_reg        <= count_next;
            pos_reg          <= pos_next;
            result_valid_reg <= have_head;
        end
    end

    // queue write and output payload
    always_ff @(posedge clk)
    begin
        if (in_valid)
            q_mem_reg[wr_ptr_reg] <= in_item;
        class_reg <= head.cls;
        neg_reg   <= head.neg;
        exp_reg   <= head.exp;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign result_valid    = result_valid_reg;
    assign number_class    = class_reg;
    assign negative        = neg_reg;
    assign binary_exponent = exp_reg;
    assign character       = char_reg;
    assign last            = last_reg;

    // no write into a full queue
    `DTHD_ASSERT_SAME(a_no_overflow, clk, rst_n, in_valid, (count_reg != QCNT_W'(QUEUE_DEPTH)) || pop)
    // a pop ends its conversion with a last word
    `DTHD_ASSERT_NEXT(a_pop_last, clk, rst_n, pop, result_valid_reg && last_reg)
    // a queued item is never left waiting
    `DTHD_ASSERT_NEXT(a_no_gap, clk, rst_n, have_head, result_valid_reg)

endmodule

### design/double_to_hex_digits.sv
// ----------------------------------------------------------------------------
// double_to_hex_digits
// Converts an IEEE binary64 encoding into a stream of hex significand
// characters with sign, class and power-of-two exponent.
// ----------------------------------------------------------------------------
// Usage:
//   A conversion is taken when start is high and busy is low. The four
//   pipeline stages (classify, align, round decision, increment) accept a new
//   word every cycle while busy is low; finished conversions wait in an
//   8-entry queue. Each character leaves as one word, result_valid high
//   for one cycle, with last set on the final character. After it is
//   accepted, a conversion passes the pipeline stages into the queue, and
//   the queue head is sent at one character per cycle, so a conversion of
//   n characters fills n output words (1 to 32; 14 typical, 8 for Infinity).
//   busy rises when 8 conversions are inside the block (pipeline and queue).
//   The receiver cannot stall: words are delivered back to back.
//   Configuration: cfg_index 0 is rounding_mode, 1 is upper_case; cfg_ready
//   is always high. Write only while no conversion is in flight.
//   Reset clears the pipeline, the queue and the output strobe and sets
//   rounding to nearest even with lower-case digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_to_hex_digits_macros.svh"

module double_to_hex_digits
    import dthd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [63:0]        value_bits,
    input  logic signed [6:0]  requested_digits,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [1:0]         cfg_data,
    output logic               result_valid,
    output logic [1:0]         number_class,
    output logic               negative,
    output logic signed [11:0] binary_exponent,
    output logic [6:0]         character,
    output logic               last
);

    logic [1:0]        rounding_mode_reg;
    logic              upper_case_reg;
    logic [QCNT_W-1:0] occ_reg, occ_next;
    logic              accept;
    logic              pop;
    logic              front_valid;
    front_t            front_word;
    logic              round_valid;
    item_t             round_item;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rounding_mode_reg <= RM_NEAREST;
            upper_case_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROUNDING: rounding_mode_reg <= cfg_data;
                REG_UPPER:    upper_case_reg    <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // conversions held inside the block, bounded by the queue size
    assign accept   = start && !busy;
    assign busy     = (occ_reg == QCNT_W'(QUEUE_DEPTH));
    assign occ_next = occ_reg + QCNT_W'(accept) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    dthd_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (accept),
        .value_bits       (value_bits),
        .requested_digits (requested_digits),
        .out_valid        (front_valid),
        .out_word         (front_word)
    );

    dthd_round u_round (
        .clk           (clk),
        .rst_n         (rst_n),
        .rounding_mode (rounding_mode_reg),
        .in_valid      (front_valid),
        .in_word       (front_word),
        .out_valid     (round_valid),
        .out_item      (round_item)
    );

    dthd_emit u_emit (
        .clk             (clk),
        .rst_n           (rst_n),
        .upper_case      (upper_case_reg),
        .in_valid        (round_valid),
        .in_item         (round_item),
        .pop             (pop),
        .result_valid    (result_valid),
        .number_class    (number_class),
        .negative        (negative),
        .binary_exponent (binary_exponent),
        .character       (character),
        .last            (last)
    );

    // occupancy never runs past the queue size
    `DTHD_ASSERT_SAME(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= QCNT_W'(QUEUE_DEPTH))

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double to hex digit converter. Directed
// conversions cover the special classes, digit count limits, subnormals and
// each rounding mode. They are followed by random phases under every
// register setting. A predictor in the bench builds the expected character
// words when a conversion is taken. Every character word is checked field by
// field against the oldest expected word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import dthd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 16;
    localparam int PHASE_ITEMS    = 23;

    // one expected character word
    typedef struct {
        logic [1:0]  cls;
        logic        neg;
        logic [11:0] bexp;
        logic [6:0]  ch;
        logic        last;
    } char_word_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [63:0]        value_bits;
    logic signed [6:0]  requested_digits;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [1:0]         cfg_data;
    logic               result_valid;
    logic [1:0]         number_class;
    logic               negative;
    logic signed [11:0] binary_exponent;
    logic [6:0]         character;
    logic               last;

    // bench copy of the registers
    logic [1:0]         round_mode = RM_NEAREST;
    logic               upper_hex  = 1'b0;

    char_word_t         expected_chars[$];
    int                 mismatch_count = 0;
    int                 quiet_cycles   = 0;
    logic               idle_on        = 1'b1;

    double_to_hex_digits uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .value_bits       (value_bits),
        .requested_digits (requested_digits),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .result_valid     (result_valid),
        .number_class     (number_class),
        .negative         (negative),
        .binary_exponent  (binary_exponent),
        .character        (character),
        .last             (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // push one expected word
    task automatic push_char(input logic [1:0] cls, input logic neg, input int e_int,
                             input logic [6:0] ch, input logic is_last);
        char_word_t w;
        w.cls  = cls;
        w.neg  = neg;
        w.bexp = e_int[11:0];
        w.ch   = ch;
        w.last = is_last;
        expected_chars.push_back(w);
    endtask

    // expected character words of one conversion
    task automatic predict_hex_digits(input logic [63:0] v, input logic [6:0] rq);
        logic [3:0]  sig [NIBBLES];
        logic [3:0]  dig [MAX_DIGITS];
        logic        sgn;
        logic [10:0] ex;
        logic [63:0] fm;
        logic [3:0]  first_cut;
        logic        rest;
        logic        up;
        logic [6:0]  ch;
        byte         b;
        string       name;
        int          e_int;
        int          nfig;
        int          nd;
        int          hb;
        int          shift;
        int          i;
        int          k;
        sgn = v[63];
        ex  = v[62:52];
        fm  = {12'd0, v[51:0]};
        for (i = 0; i < NIBBLES; i++)
            sig[i] = 4'd0;

        // names of the non-finite classes
        if (ex == 11'h7FF)
        begin
            if (fm != 0)
                name = "NaN";
            else
                name = "Infinity";
            for (k = 0; k < name.len(); k++)
            begin
                b = name[k];
                push_char((fm != 0) ? CLS_NAN : CLS_INF, sgn, 0, b[6:0],
                          k == name.len() - 1);
            end
            return;
        end
        if (ex == 11'd0 && fm == 0)
        begin
            push_char(CLS_ZERO, sgn, 1, 7'h30, 1'b1);
            return;
        end

        // significand nibbles
        if (ex != 11'd0)
        begin
            nfig   = NIBBLES;
            e_int  = int'(ex) - 1022;
            sig[0] = 4'd1;
            for (i = 1; i < NIBBLES; i++)
                sig[i] = fm[4 * (13 - i) +: 4];
        end
        else
        begin
            hb = 51;
            while (hb > 0 && !fm[hb])
                hb--;
            shift = 52 - hb;
            nfig  = (4 + hb) / 4;
            e_int = -1021 - ((shift + 3) & ~3);
            for (i = 0; i < nfig; i++)
                sig[i] = fm[4 * (nfig - 1 - i) +: 4];
        end

        // digit count
        if (rq[6])
        begin
            nd = nfig;
            while (nd > 1 && sig[nd - 1] == 4'd0)
                nd--;
        end
        else if (rq == 7'd0)
            nd = 1;
        else
            nd = (rq > 7'(MAX_DIGITS)) ? MAX_DIGITS : int'(rq);

        for (k = 0; k < nd; k++)
            dig[k] = (k < nfig) ? sig[k] : 4'd0;

        // rounding of the cut-off digits
        if (nfig > nd)
        begin
            first_cut = sig[nd];
            rest = 1'b0;
            for (i = nd + 1; i < nfig; i++)
                if (sig[i] != 4'd0)
                    rest = 1'b1;
            case (round_mode)
                RM_NEAREST: up = first_cut > 4'd8 ||
                                 (first_cut == 4'd8 && (rest || sig[nd - 1][0]));
                RM_UP:      up = (first_cut != 4'd0 || rest) && !sgn;
                RM_DOWN:    up = (first_cut != 4'd0 || rest) && sgn;
                default:    up = 1'b0;
            endcase
            if (up)
            begin
                k = nd - 1;
                while (k >= 0 && dig[k] == 4'hF)
                begin
                    dig[k] = 4'd0;
                    k--;
                end
                if (k < 0)
                begin
                    dig[0] = 4'd1;
                    e_int += 4;
                end
                else
                    dig[k] = dig[k] + 4'd1;
            end
        end

        // ascii digits
        for (k = 0; k < nd; k++)
        begin
            if (dig[k] < 4'd10)
                ch = 7'h30 + {3'd0, dig[k]};
            else
                ch = (upper_hex ? 7'h41 : 7'h61) + {3'd0, dig[k]} - 7'd10;
            push_char(CLS_FINITE, sgn, e_int, ch, k == nd - 1);
        end
    endtask

    // send one conversion word, start left high on return
    task automatic convert_value(input logic [63:0] v, input logic [6:0] rq);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start            <= 1'b1;
        value_bits       <= v;
        requested_digits <= rq;
        do
            @(posedge clk);
        while (busy);
        predict_hex_digits(v, rq);
    endtask

    // stop sending and wait for every expected word
    task automatic drain_chars();
        start <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // write both registers while the block is idle
    task automatic set_config(input logic [1:0] rm, input logic upper);
        drain_chars();
        cfg_valid <= 1'b1;
        cfg_index <= REG_ROUNDING;
        cfg_data  <= rm;
        do
            @(posedge clk);
        while (!cfg_ready);
        round_mode = rm;
        cfg_index <= REG_UPPER;
        cfg_data  <= {1'b0, upper};
        do
            @(posedge clk);
        while (!cfg_ready);
        upper_hex = upper;
        cfg_valid <= 1'b0;
    endtask

    // digit count with the limits and the negative range mixed in
    function automatic logic [6:0] random_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 7'($urandom_range(1, 15));
        else if (pick < 70)
            return 7'h7F;
        else if (pick < 78)
            return 7'd0;
        else if (pick < 90)
            return 7'($urandom_range(16, 32));
        else if (pick < 95)
            return 7'($urandom_range(33, 63));
        else
            return 7'($urandom_range(64, 126));
    endfunction

    // random conversion word biased towards rounding boundaries
    task automatic random_item(output logic [63:0] v, output logic [6:0] rq);
        logic [63:0] r;
        logic        tie;
        logic        f_run;
        int          kind;
        int          c;
        int          i;
        r    = {$urandom, $urandom};
        rq   = random_count();
        kind = $urandom_range(0, 99);
        if (kind < 50)
            v = r;
        else if (kind < 65)
            v = {r[63], 11'd0, r[51:0] >> $urandom_range(0, 51)};
        else if (kind < 88)
        begin
            // cut c low nibbles, half ties, half carry runs above the cut
            c     = $urandom_range(1, 12);
            tie   = 1'($urandom_range(0, 1));
            f_run = 1'($urandom_range(0, 1));
            v     = r;
            for (i = 0; i < 13; i++)
            begin
                if (i == c - 1 && tie)
                    v[4 * i +: 4] = 4'h8;
                else if (i < c - 1 && tie)
                    v[4 * i +: 4] = 4'h0;
                else if (i >= c && f_run)
                    v[4 * i +: 4] = 4'hF;
            end
            if ($urandom_range(0, 3) == 0)
                v[62:52] = 11'd0;
            else if (v[62:52] == 11'h7FF)
                v[62:52] = 11'h3FF;
            rq = 7'(14 - c);
        end
        else
        begin
            case ($urandom_range(0, 4))
                0: v = {r[63], 63'd0};
                1: v = {r[63], 11'h7FF, 52'd0};
                2: v = {r[63], 11'h7FF, r[51:1], 1'b1};
                3: v = {r[63], 11'h7FE, 52'hFFFFFFFFFFFFF};
                default: v = {r[63], 11'h001, r[51:0]};
            endcase
        end
    endtask

    // zero, infinity and nan of both signs
    task automatic test_special_values();
        convert_value(64'h0000000000000000, 7'h7F);
        convert_value(64'h8000000000000000, 7'd5);
        convert_value(64'h7FF0000000000000, 7'd1);
        convert_value(64'hFFF0000000000000, 7'h7F);
        convert_value(64'h7FF8000000000000, 7'd3);
        convert_value(64'h7FF0000000000001, 7'd0);
        convert_value(64'hFFFFFFFFFFFFFFFF, 7'd32);
    endtask

    // shortest, zero, saturated and negative digit counts
    task automatic test_digit_counts();
        convert_value(64'h3FF23456789ABCDE, 7'h40);
        convert_value(64'h3FF23456789ABCDE, 7'h7F);
        convert_value(64'h3FF23456789ABCDE, 7'd0);
        convert_value(64'h3FF23456789ABCDE, 7'd1);
        convert_value(64'h3FF23456789ABCDE, 7'd14);
        convert_value(64'h3FF23456789ABCDE, 7'd32);
        convert_value(64'h3FF23456789ABCDE, 7'd63);
        convert_value(64'h4000000000000000, 7'h7F);
        convert_value(64'h7FEFFFFFFFFFFFFF, 7'd20);
        convert_value(64'h0010000000000000, 7'h7F);
    endtask

    // smallest and largest subnormals
    task automatic test_subnormals();
        convert_value(64'h0000000000000001, 7'h7F);
        convert_value(64'h800FFFFFFFFFFFFF, 7'd32);
    endtask

    // ties, full carry and truncation in every mode
    task automatic test_rounding_modes();
        set_config(RM_NEAREST, 1'b1);
        convert_value(64'h3FF0800000000000, 7'd2);
        convert_value(64'h3FF1800000000000, 7'd2);
        set_config(RM_UP, 1'b0);
        convert_value(64'h000FFFFFFFFFFFFF, 7'd1);
        convert_value(64'h800FFFFFFFFFFFFF, 7'd1);
        set_config(RM_DOWN, 1'b1);
        convert_value(64'h800FFFFFFFFFFFFF, 7'd1);
        set_config(RM_ZERO, 1'b0);
        convert_value(64'h3FFFFFFFFFFFFFFF, 7'd3);
    endtask

    // random phases under every register setting, last one without gaps
    task automatic test_random_phases();
        logic [1:0]  modes [8];
        logic        cases [8];
        logic [63:0] v;
        logic [6:0]  rq;
        int          p;
        int          n;
        modes = '{RM_ZERO, RM_NEAREST, RM_UP, RM_DOWN, RM_UP, RM_DOWN, RM_NEAREST, RM_ZERO};
        cases = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        for (p = 0; p < 8; p++)
        begin
            set_config(modes[p], cases[p]);
            idle_on = (p < 7) && ($urandom_range(0, 3) != 0);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                random_item(v, rq);
                convert_value(v, rq);
            end
        end
    endtask

    // stimulus
    initial
    begin
        rst_n            <= 1'b0;
        start            <= 1'b0;
        value_bits       <= 64'd0;
        requested_digits <= 7'd0;
        cfg_valid        <= 1'b0;
        cfg_index        <= REG_ROUNDING;
        cfg_data         <= RM_NEAREST;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_special_values();
        test_digit_counts();
        test_subnormals();
        test_rounding_modes();
        test_random_phases();

        drain_chars();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // compare one field and report a mismatch
    task automatic check_field(input string field, input logic [11:0] want,
                               input logic [11:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        end
    endtask

    // check each character word against the oldest expected word
    always @(posedge clk)
    begin
        char_word_t w;
        if (rst_n && result_valid)
        begin
            if (expected_chars.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: word with nothing expected, expected none got char %0h",
                         $time, character);
            end
            else
            begin
                w = expected_chars.pop_front();
                check_field("number_class", {10'd0, w.cls}, {10'd0, number_class});
                check_field("negative", {11'd0, w.neg}, {11'd0, negative});
                check_field("binary_exponent", w.bexp, binary_exponent);
                check_field("character", {5'd0, w.ch}, {5'd0, character});
                check_field("last", {11'd0, w.last}, {11'd0, last});
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

### double_to_hex_digits.f
+incdir+design
design/dthd_pkg.sv
design/dthd_front.sv
design/dthd_round.sv
design/dthd_emit.sv
design/double_to_hex_digits.sv
tb/tb_top.sv
